>>> sv/halfstep_stepper_homing_controller_core_defines.svh
// Assertion macros shared by the stepper homing controller RTL.
`ifndef HALFSTEP_STEPPER_HOMING_CONTROLLER_CORE_DEFINES_SVH
`define HALFSTEP_STEPPER_HOMING_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HSSHC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsshc same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HSSHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsshc next-cycle check failed");

`endif

>>> sv/hsshc_pkg.sv
// Types, codes and tables of the half-step stepper homing controller.
`default_nettype none

package hsshc_pkg;

	// command codes carried in the opcode field
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_CAL   = 3'd1;
	localparam logic [2:0] OP_RUN   = 3'd2;
	localparam logic [2:0] OP_DISP  = 3'd3;
	localparam logic [2:0] OP_RECAL = 3'd4;

	// configuration register indexes
	localparam logic REG_OFFSET_STEPS = 1'b0;

	localparam int          OFFSET_W       = 10;
	localparam logic [9:0]  OFFSET_RESET   = 10'd110;
	localparam int          REM_W          = 22;
	localparam int          CAL_W          = 18;
	localparam logic [17:0] CAL_MAX        = 18'h3FFFF;
	localparam int          REV_W          = 16;
	localparam logic [2:0]  CAL_EDGES      = 3'd4;

	// floor(x/3) = (x * DIV3_MULT) >> DIV3_SHIFT for every 18-bit x
	localparam logic [17:0] DIV3_MULT  = 18'd174763;
	localparam int          DIV3_SHIFT = 19;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_CAL,
		MODE_SEEK,
		MODE_MOVE
	} mode_t;

	// half-step coil pattern for a phase, bit0 is coil one
	function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
		logic [3:0] pat;
		unique case (ph)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

>>> sv/halfstep_stepper_homing_controller_core.sv
// Half-step stepper sequencer with index-sensor calibration, runs and dispensing.
`default_nettype none

// One input transfer is one step period; every transfer yields exactly one
// result transfer carrying the coil pattern after that period and the status.
// An item is captured into an input register, and all its work (command
// decode, calibration edge counting, divide by three, phase step, move
// counting) is done in one pass of logic into the result register, so the
// block takes one item per clock cycle; only backpressure on the result side
// slows it. The offset_steps register sits at byte address 0 of the APB port;
// the user must see it is written only while the block is idle; no check enforces it.
module halfstep_stepper_homing_controller_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[2:0], step_count[18:3], reverse[19], sensor[20]
	input  wire logic [hsshc_pkg::IN_DATA_W-1:0] s_tdata,
	// stream out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// coils[3:0], busy_res[4], is_calibrated[5], rejected[6], steps_per_rev[22:7]
	output logic [hsshc_pkg::OUT_DATA_W-1:0] m_tdata,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import hsshc_pkg::*;

	// input stage
	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic [15:0] step_count_s1;
	logic        reverse_s1;
	logic        sensor_s1;
	logic        take_s1;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// block state
	logic [OFFSET_W-1:0] offset_steps_q;
	mode_t               mode_q, mode_d;
	logic [2:0]          phase_q, phase_d;
	logic                calibrated_q, calibrated_d;
	logic [REV_W-1:0]    rev_steps_q, rev_steps_d;
	logic [7:0]          dispense_count_q, dispense_count_d;
	logic [REM_W-1:0]    remaining_q, remaining_d;
	logic                move_reverse_q, move_reverse_d;
	logic [2:0]          edge_count_q, edge_count_d;
	logic [CAL_W-1:0]    cal_steps_q, cal_steps_d;
	logic                last_sensor_q, last_sensor_d;
	logic                follow_fwd_q, follow_fwd_d;
	logic                rejected_d;

	// arithmetic helpers
	logic [CAL_W-1:0]   cal_inc;
	logic [2*CAL_W-1:0] div3_prod;
	logic [16:0]        cal_avg;
	logic [REM_W-1:0]   follow_prod;
	logic [REM_W-1:0]   eighth_rev;
	logic [OUT_DATA_W-1:0] out_data_d;

	logic cfg_write;

	// handshake
	assign take_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || take_s1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_OFFSET_STEPS);
	assign prdata    = (paddr[2] == REG_OFFSET_STEPS) ?
		{{(32-OFFSET_W){1'b0}}, offset_steps_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_steps_q <= OFFSET_RESET;
		end else if (cfg_write) begin
			offset_steps_q <= pwdata[OFFSET_W-1:0];
		end
	end

	// capture an input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1     <= s_tdata[2:0];
			step_count_s1 <= s_tdata[18:3];
			reverse_s1    <= s_tdata[19];
			sensor_s1     <= s_tdata[20];
		end
	end

	// divide the saturating calibration count by three
	assign cal_inc   = (edge_count_q != 3'd0 && cal_steps_q != CAL_MAX) ?
		cal_steps_q + 1'b1 : cal_steps_q;
	assign div3_prod = cal_inc * DIV3_MULT;
	assign cal_avg   = div3_prod[DIV3_SHIFT +: 17];

	// one eighth of a revolution, and the return move after a recalibration
	assign eighth_rev  = {{(REM_W-REV_W+3){1'b0}}, rev_steps_q[REV_W-1:3]};
	assign follow_prod = eighth_rev * {{(REM_W-8){1'b0}}, dispense_count_q};

	// next state for one step period
	always_comb begin
		logic started;
		started          = 1'b0;
		mode_d           = mode_q;
		phase_d          = phase_q;
		calibrated_d     = calibrated_q;
		rev_steps_d      = rev_steps_q;
		dispense_count_d = dispense_count_q;
		remaining_d      = remaining_q;
		move_reverse_d   = move_reverse_q;
		edge_count_d     = edge_count_q;
		cal_steps_d      = cal_steps_q;
		last_sensor_d    = last_sensor_q;
		follow_fwd_d     = follow_fwd_q;
		rejected_d       = 1'b0;

		// decode the command
		if (opcode_s1 == OP_CAL || opcode_s1 == OP_RUN ||
				opcode_s1 == OP_DISP || opcode_s1 == OP_RECAL) begin
			if (mode_q != MODE_IDLE) begin
				rejected_d = 1'b1;
			end else begin
				unique case (opcode_s1)
					OP_CAL: begin
						mode_d        = MODE_CAL;
						last_sensor_d = sensor_s1;
						edge_count_d  = 3'd0;
						cal_steps_d   = '0;
						started       = 1'b1;
					end
					OP_RUN: begin
						if (calibrated_q) begin
							mode_d         = MODE_MOVE;
							remaining_d    = {{(REM_W-16){1'b0}}, step_count_s1};
							move_reverse_d = reverse_s1;
							follow_fwd_d   = 1'b0;
						end else begin
							rejected_d = 1'b1;
						end
					end
					OP_DISP: begin
						dispense_count_d = dispense_count_q + 1'b1;
						if (calibrated_q) begin
							mode_d         = MODE_MOVE;
							remaining_d    = eighth_rev;
							move_reverse_d = 1'b0;
							follow_fwd_d   = 1'b0;
						end else begin
							rejected_d = 1'b1;
						end
					end
					default: begin
						if (calibrated_q) begin
							mode_d        = MODE_SEEK;
							last_sensor_d = sensor_s1;
							started       = 1'b1;
						end else begin
							rejected_d = 1'b1;
						end
					end
				endcase
			end
		end

		// count index edges, or seek the sensor change
		if (mode_d == MODE_CAL && !started) begin
			cal_steps_d = cal_inc;
			if (last_sensor_q && !sensor_s1) begin
				edge_count_d = edge_count_q + 1'b1;
			end
			last_sensor_d = sensor_s1;
			if (edge_count_d == CAL_EDGES) begin
				calibrated_d   = 1'b1;
				rev_steps_d    = cal_avg[16] ? {REV_W{1'b1}} : cal_avg[REV_W-1:0];
				mode_d         = MODE_MOVE;
				remaining_d    = {{(REM_W-OFFSET_W){1'b0}}, offset_steps_q};
				move_reverse_d = 1'b0;
				follow_fwd_d   = 1'b0;
			end else begin
				phase_d = phase_d + 1'b1;
			end
		end else if (mode_d == MODE_SEEK) begin
			if (!started && sensor_s1 != last_sensor_q) begin
				mode_d         = MODE_MOVE;
				remaining_d    = {{(REM_W-OFFSET_W){1'b0}}, offset_steps_q};
				move_reverse_d = 1'b1;
				follow_fwd_d   = 1'b1;
			end else begin
				phase_d = phase_d - 1'b1;
			end
		end

		// advance one half-step of a move
		if (mode_d == MODE_MOVE) begin
			if (remaining_d != '0) begin
				phase_d     = move_reverse_d ? phase_d - 1'b1 : phase_d + 1'b1;
				remaining_d = remaining_d - 1'b1;
			end
			if (remaining_d == '0) begin
				if (follow_fwd_d) begin
					remaining_d    = follow_prod;
					move_reverse_d = 1'b0;
					follow_fwd_d   = 1'b0;
					if (follow_prod == '0) begin
						mode_d = MODE_IDLE;
					end
				end else begin
					mode_d = MODE_IDLE;
				end
			end
		end
	end

	// result fields
	always_comb begin
		out_data_d       = '0;
		out_data_d[3:0]  = coil_pattern(phase_d);
		out_data_d[4]    = (mode_d != MODE_IDLE);
		out_data_d[5]    = calibrated_d;
		out_data_d[6]    = rejected_d;
		out_data_d[22:7] = rev_steps_d;
	end

	// commit state for the item taken this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_IDLE;
			phase_q          <= 3'd0;
			calibrated_q     <= 1'b0;
			rev_steps_q      <= '0;
			dispense_count_q <= 8'd0;
			remaining_q      <= '0;
			move_reverse_q   <= 1'b0;
			edge_count_q     <= 3'd0;
			cal_steps_q      <= '0;
			last_sensor_q    <= 1'b0;
			follow_fwd_q     <= 1'b0;
		end else if (take_s1) begin
			mode_q           <= mode_d;
			phase_q          <= phase_d;
			calibrated_q     <= calibrated_d;
			rev_steps_q      <= rev_steps_d;
			dispense_count_q <= dispense_count_d;
			remaining_q      <= remaining_d;
			move_reverse_q   <= move_reverse_d;
			edge_count_q     <= edge_count_d;
			cal_steps_q      <= cal_steps_d;
			last_sensor_q    <= last_sensor_d;
			follow_fwd_q     <= follow_fwd_d;
		end
	end

	// hold or load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			out_data_q <= out_data_d;
		end
	end

`include "halfstep_stepper_homing_controller_core_defines.svh"

	`HSSHC_ASSERT_IMPL(a_motion_needs_cal, (mode_q == MODE_SEEK || mode_q == MODE_MOVE), calibrated_q)
	`HSSHC_ASSERT_NEXT(a_cal_sticky, calibrated_q, calibrated_q)
	`HSSHC_ASSERT_IMPL(a_idle_no_remaining, (mode_q == MODE_IDLE), (remaining_q == '0))
	`HSSHC_ASSERT_NEXT(a_item_gives_result, take_s1, out_valid_q)

endmodule

`default_nettype wire

>>> verif/halfstep_stepper_homing_controller_core_tb.sv
// Self-checking testbench for the half-step stepper homing controller core.
`default_nettype none

module halfstep_stepper_homing_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsshc_pkg::*;

	// opcodes that the block treats as a plain step period
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int LATENCY     = 2;

	// one step period, packed as it travels in s_tdata
	typedef struct packed {
		logic        sensor;
		logic        reverse;
		logic [15:0] step_count;
		logic [2:0]  opcode;
	} period_t;

	// one status transfer, packed as it travels in m_tdata
	typedef struct packed {
		logic [15:0] steps_per_rev;
		logic        rejected;
		logic        calibrated;
		logic        busy;
		logic [3:0]  coils;
	} status_t;

	// Tracks the controller state and holds the status expected for each period.
	class coil_status_scoreboard;
		logic [9:0]  offset;
		mode_t       mode;
		logic [2:0]  phase;
		logic        calibrated;
		logic [15:0] rev_steps;
		logic [7:0]  dispense_count;
		logic [21:0] remaining;
		logic        move_reverse;
		logic [2:0]  edges_seen;
		logic [17:0] cal_steps;
		logic        last_sensor;
		logic        follow_fwd;
		status_t     expected_status[$];
		int          errors;

		function new();
			offset         = OFFSET_RESET;
			mode           = MODE_IDLE;
			phase          = 3'd0;
			calibrated     = 1'b0;
			rev_steps      = 16'd0;
			dispense_count = 8'd0;
			remaining      = 22'd0;
			move_reverse   = 1'b0;
			edges_seen     = 3'd0;
			cal_steps      = 18'd0;
			last_sensor    = 1'b0;
			follow_fwd     = 1'b0;
			errors         = 0;
		endfunction

		function bit busy();
			return mode != MODE_IDLE;
		endfunction

		function logic [3:0] coil_for(logic [2:0] ph);
			case (ph)
				3'd0: return 4'h1;
				3'd1: return 4'h3;
				3'd2: return 4'h2;
				3'd3: return 4'h6;
				3'd4: return 4'h4;
				3'd5: return 4'hC;
				3'd6: return 4'h8;
				default: return 4'h9;
			endcase
		endfunction

		function void begin_move(logic [21:0] count, logic back, logic fwd_after);
			mode         = MODE_MOVE;
			remaining    = count;
			move_reverse = back;
			follow_fwd   = fwd_after;
		endfunction

		// Apply one accepted period; return the phase step taken (+1, -1 or 0).
		function int note_period(period_t p);
			status_t     s;
			logic        refused;
			bit          started;
			logic [17:0] third;
			logic [2:0]  old_phase;
			refused   = 1'b0;
			started   = 1'b0;
			old_phase = phase;

			// decode the command; any motion or calibration command while busy is refused
			if (p.opcode >= OP_CAL && p.opcode <= OP_RECAL) begin
				if (mode != MODE_IDLE) begin
					refused = 1'b1;
				end else begin
					case (p.opcode)
						OP_CAL: begin
							mode        = MODE_CAL;
							last_sensor = p.sensor;
							edges_seen  = 3'd0;
							cal_steps   = 18'd0;
							started     = 1'b1;
						end
						OP_RUN: begin
							if (calibrated)
								begin_move(22'(p.step_count), p.reverse, 1'b0);
							else
								refused = 1'b1;
						end
						OP_DISP: begin
							dispense_count = dispense_count + 8'd1;
							if (calibrated)
								begin_move(22'(rev_steps >> 3), 1'b0, 1'b0);
							else
								refused = 1'b1;
						end
						default: begin
							if (calibrated) begin
								mode        = MODE_SEEK;
								last_sensor = p.sensor;
								started     = 1'b1;
							end else begin
								refused = 1'b1;
							end
						end
					endcase
				end
			end

			// count steps and falling index edges over three revolutions
			if (mode == MODE_CAL && !started) begin
				if (edges_seen != 3'd0 && cal_steps != CAL_MAX)
					cal_steps = cal_steps + 18'd1;
				if (last_sensor && !p.sensor)
					edges_seen = edges_seen + 3'd1;
				last_sensor = p.sensor;
				if (edges_seen == CAL_EDGES) begin
					third      = cal_steps / 18'd3;
					calibrated = 1'b1;
					rev_steps  = (third > 18'h0FFFF) ? 16'hFFFF : third[15:0];
					begin_move(22'(offset), 1'b0, 1'b0);
				end else begin
					phase = phase + 3'd1;
				end
			end else if (mode == MODE_SEEK) begin
				// step back until the index level changes, then back off
				if (!started && p.sensor != last_sensor)
					begin_move(22'(offset), 1'b1, 1'b1);
				else
					phase = phase - 3'd1;
			end

			// one half-step per period; chain the forward return after a seek
			if (mode == MODE_MOVE) begin
				if (remaining != 22'd0) begin
					phase     = move_reverse ? phase - 3'd1 : phase + 3'd1;
					remaining = remaining - 22'd1;
				end
				if (remaining == 22'd0) begin
					if (follow_fwd) begin
						begin_move(22'(rev_steps >> 3) * 22'(dispense_count), 1'b0, 1'b0);
						if (remaining == 22'd0)
							mode = MODE_IDLE;
					end else begin
						mode = MODE_IDLE;
					end
				end
			end

			s.coils         = coil_for(phase);
			s.busy          = mode != MODE_IDLE;
			s.calibrated    = calibrated;
			s.rejected      = refused;
			s.steps_per_rev = rev_steps;
			expected_status.push_back(s);

			if (phase == old_phase)
				return 0;
			return (phase == old_phase + 3'd1) ? 1 : -1;
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (expected_status.size() == 0) begin
				$error("status transfer with nothing expected: %h", got);
				errors++;
				return;
			end
			want = expected_status.pop_front();
			if (got.coils !== want.coils) begin
				$error("coils: expected %h, actual %h", want.coils, got.coils);
				errors++;
			end
			if (got.busy !== want.busy) begin
				$error("busy_res: expected %b, actual %b", want.busy, got.busy);
				errors++;
			end
			if (got.calibrated !== want.calibrated) begin
				$error("is_calibrated: expected %b, actual %b", want.calibrated,
					got.calibrated);
				errors++;
			end
			if (got.rejected !== want.rejected) begin
				$error("rejected: expected %b, actual %b", want.rejected, got.rejected);
				errors++;
			end
			if (got.steps_per_rev !== want.steps_per_rev) begin
				$error("steps_per_rev: expected %0d, actual %0d", want.steps_per_rev,
					got.steps_per_rev);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // opcode[2:0], step_count[18:3], reverse[19], sensor[20]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // coils[3:0], busy_res[4], is_calibrated[5], rejected[6],
	                        // steps_per_rev[22:7]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	coil_status_scoreboard sb = new();

	int send_idle;
	int recv_idle;
	int rx_hold;
	int items_sent;
	int stall_cycles;

	// slotted index disk: the sensor sees a window of disk_high steps per turn
	int disk_pos;
	int disk_rev;
	int disk_high;
	bit sensor_noise;

	halfstep_stepper_homing_controller_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// check every status transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(status_t'(m_tdata[22:0]));
	end

	// drive result-side backpressure; a hold request stalls it outright
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (recv_idle == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// end the run if neither side moves a transfer for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("halfstep_stepper_homing_controller_core_tb: done, errors");
			$finish;
		end
	end

	function automatic logic disk_sensor();
		int   m;
		logic lvl;
		m = disk_pos % disk_rev;
		if (m < 0)
			m += disk_rev;
		lvl = (m < disk_high);
		if (sensor_noise && $urandom_range(99) < 4)
			lvl = !lvl;
		return lvl;
	endfunction

	// offer one period, wait for its transfer and turn the disk with the motor
	task automatic send_period(input period_t p);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, p};
		do @(posedge clk); while (!s_tready);
		disk_pos += sb.note_period(p);
		items_sent++;
	endtask

	task automatic issue(input logic [2:0] op, input logic [15:0] cnt, input logic rev);
		period_t p;
		p.opcode     = op;
		p.step_count = cnt;
		p.reverse    = rev;
		p.sensor     = disk_sensor();
		send_period(p);
	endtask

	// feed periods until the motion ends, now and then with a random opcode, refused if it is a command
	task automatic settle(input bit with_cmds);
		while (sb.busy()) begin
			if (with_cmds && $urandom_range(9) == 0)
				issue(3'($urandom_range(7, 1)), 16'($urandom), 1'($urandom));
			else
				issue(OP_TICK, 16'($urandom), 1'($urandom));
		end
	endtask

	task automatic calibrate(input int rev_len, input int high_len);
		disk_rev  = rev_len;
		disk_high = high_len;
		issue(OP_CAL, 16'($urandom), 1'($urandom));
		settle(1'b0);
	endtask

	// stop offering and wait until every expected status has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_status.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// read offset_steps and compare it with the value it should hold
	task automatic check_offset(input logic [9:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 3'(4 * REG_OFFSET_STEPS);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(want)) begin
			$error("offset_steps: expected %0d, actual %0d", want, prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write offset_steps, then read it back over the same selection
	task automatic write_offset(input logic [9:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * REG_OFFSET_STEPS);
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.offset = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(value)) begin
			$error("offset_steps: expected %0d, actual %0d", value, prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [15:0] run_length();
		if ($urandom_range(15) == 0)
			return 16'($urandom_range(400));
		return 16'($urandom_range(24));
	endfunction

	// mostly complete command sequences on a fresh or known disk, some noise
	task automatic random_phase(input int budget, input bit squeeze);
		int first;
		int r;
		bit held;
		first = items_sent;
		held  = 1'b0;
		while (items_sent - first < budget) begin
			if (squeeze && !held && items_sent - first >= budget / 2) begin
				rx_hold = HOLD_CYCLES;
				held    = 1'b1;
			end
			sensor_noise = ($urandom_range(9) < 2);
			r = $urandom_range(99);
			if (!sb.calibrated || r < 10) begin
				disk_rev  = $urandom_range(40, 8);
				disk_high = $urandom_range(disk_rev - 1, 1);
				issue(OP_CAL, 16'($urandom), 1'($urandom));
			end else if (r < 45) begin
				issue(OP_RUN, run_length(), 1'($urandom));
			end else if (r < 62) begin
				issue(OP_DISP, 16'($urandom), 1'($urandom));
			end else if (r < 72) begin
				issue(OP_RECAL, 16'($urandom), 1'($urandom));
			end else if (r < 86) begin
				issue(OP_TICK, 16'($urandom), 1'($urandom));
			end else begin
				issue(3'($urandom_range(7, 5)), 16'($urandom), 1'($urandom));
			end
			settle(1'b1);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		send_idle    = 30;
		recv_idle    = 70;
		rx_hold      = 0;
		items_sent   = 0;
		stall_cycles = 0;
		disk_pos     = 0;
		disk_rev     = 12;
		disk_high    = 5;
		sensor_noise = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// the offset register leaves reset at its default
		check_offset(OFFSET_RESET);
		@(posedge clk);

		// zero offset: the move after calibration ends in its first period
		write_offset(10'd0);
		issue(OP_TICK, 16'hFFFF, 1'b1);
		issue(OP_SPARE5, 16'h0000, 1'b0);
		issue(OP_SPARE6, 16'hA5A5, 1'b1);
		issue(OP_SPARE7, 16'h5A5A, 1'b0);

		// refuse motion before calibration; dispense still counts and wraps
		issue(OP_RUN, 16'd4, 1'b0);
		issue(OP_RECAL, 16'd0, 1'b0);
		repeat (257) issue(OP_DISP, 16'($urandom), 1'($urandom));

		// calibrate, with every command refused while it is running
		issue(OP_CAL, 16'd0, 1'b0);
		issue(OP_DISP, 16'd0, 1'b0);
		issue(OP_RUN, 16'd9, 1'b1);
		issue(OP_RECAL, 16'd0, 1'b0);
		issue(OP_CAL, 16'd0, 1'b0);
		settle(1'b0);

		// runs of zero, forward and backward steps, dispense, recalibrate
		issue(OP_RUN, 16'd0, 1'b0);
		issue(OP_RUN, 16'd5, 1'b0);
		settle(1'b0);
		issue(OP_RUN, 16'd3, 1'b1);
		settle(1'b0);
		issue(OP_DISP, 16'd0, 1'b0);
		settle(1'b0);
		issue(OP_RECAL, 16'd0, 1'b0);
		settle(1'b0);
		calibrate(10, 3);

		// largest offset reads back; a short one keeps the moves brief
		drain();
		write_offset(10'd1023);
		@(posedge clk);
		write_offset(10'd25);
		calibrate(16, 8);
		issue(OP_RECAL, 16'd0, 1'b0);
		settle(1'b0);
		issue(OP_RUN, 16'd100, 1'b1);
		settle(1'b1);

		// sender calm, receiver mostly stalled
		drain();
		write_offset(10'd1);
		random_phase(180, 1'b0);

		// sender mostly idle, receiver calm
		drain();
		write_offset(10'($urandom_range(20, 2)));
		send_idle = 70;
		recv_idle = 30;
		random_phase(180, 1'b0);

		// full rate, with one long receiver hold in the middle
		drain();
		write_offset(10'($urandom_range(20, 2)));
		send_idle = 0;
		recv_idle = 0;
		random_phase(180, 1'b1);

		drain();
		if (sb.errors == 0)
			$display("halfstep_stepper_homing_controller_core_tb: done, clean");
		else
			$display("halfstep_stepper_homing_controller_core_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/hsshc_pkg.sv
sv/halfstep_stepper_homing_controller_core.sv
verif/halfstep_stepper_homing_controller_core_tb.sv
